### hw/rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared widths, constants and types for the 4x4 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

	localparam int DATA_W        = 32;
	localparam int POS_W         = 4;
	localparam int K_W           = 2;
	localparam int CNT_W         = 5;
	localparam int ACC_W         = 2 * DATA_W + 2;
	localparam int DEF_FRAC_BITS = 16;

	localparam logic [K_W-1:0]   K_LAST   = 2'd3;
	localparam logic [POS_W-1:0] POS_LAST = 4'd15;

	// one multiply-accumulate request
	typedef struct packed {
		logic             vld;
		logic [K_W-1:0]   k;
		logic [POS_W-1:0] pos;
	} op_t;

	// one finished product element
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] product;
		logic [POS_W-1:0]  position;
		logic              saturated;
		logic              final_res;
	} res_t;

endpackage

### hw/rtl/mm4_store.sv
// ----------------------------------------------------------------------------
// mm4_store
// 16-entry matrix store, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mm4_store
	import mm4_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [POS_W-1:0]  waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [POS_W-1:0]  raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**POS_W];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/mm4_mac.sv
// ----------------------------------------------------------------------------
// mm4_mac
// Shared multiply-accumulate unit: multiply, scale, sum four terms, saturate.
// ----------------------------------------------------------------------------
module mm4_mac
	import mm4_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  op_t               op,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output res_t              res
);

	op_t                     op_s1, op_s2, op_s3;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    prod_sh;
	logic signed [ACC_W-1:0]    acc_q;
	logic [ACC_W-DATA_W:0]      acc_hi;
	logic                       ovf;
	logic                       res_vld_q;
	logic [DATA_W-1:0]          product_q;
	logic [POS_W-1:0]           position_q;
	logic                       saturated_q;
	logic                       final_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
			op_s3 <= '0;
		end else begin
			op_s1 <= op;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a) * $signed(b);
	end

	assign prod_ext = {{(ACC_W-2*DATA_W){prod_s2[2*DATA_W-1]}}, prod_s2};
	assign prod_sh  = prod_ext >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (op_s2.vld) begin
			if (op_s2.k == '0) begin
				acc_q <= prod_sh;
			end else begin
				acc_q <= acc_q + prod_sh;
			end
		end
	end

	// clipped when the 32-bit sign bit and the bits above it are not all equal
	assign acc_hi = acc_q[ACC_W-1:DATA_W-1];
	assign ovf    = !((&acc_hi) || !(|acc_hi));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= op_s3.vld && (op_s3.k == K_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (op_s3.vld && (op_s3.k == K_LAST)) begin
			position_q  <= op_s3.pos;
			saturated_q <= ovf;
			final_res_q <= (op_s3.pos == POS_LAST);
			if (!ovf) begin
				product_q <= acc_q[DATA_W-1:0];
			end else if (acc_q[ACC_W-1]) begin
				product_q <= {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				product_q <= {1'b0, {(DATA_W-1){1'b1}}};
			end
		end
	end

	assign res = '{vld: res_vld_q, product: product_q, position: position_q,
		saturated: saturated_q, final_res: final_res_q};

endmodule

### hw/rtl/mm4_seq.sv
// ----------------------------------------------------------------------------
// mm4_seq
// Sequencer: counts loaded elements, then steps the MAC over 16 x 4 terms.
// ----------------------------------------------------------------------------
module mm4_seq
	import mm4_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             out_busy,
	input  logic             res_vld,
	output logic             left_we,
	output logic             right_we,
	output logic [POS_W-1:0] waddr,
	output logic [POS_W-1:0] raddr_l,
	output logic [POS_W-1:0] raddr_r,
	output op_t              op
);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] load_cnt_q;
	logic [POS_W-1:0] pos_q;
	logic [K_W-1:0]   k_q;
	logic             busy_q;
	logic             issue_q;
	logic             accept;
	logic             start;

	assign in_ready = (state_q == ST_LOAD);
	assign accept   = in_valid && in_ready;
	assign start    = (state_q == ST_RUN) && !busy_q && !out_busy;

	assign left_we  = accept && !load_cnt_q[CNT_W-1];
	assign right_we = accept && load_cnt_q[CNT_W-1];
	assign waddr    = load_cnt_q[POS_W-1:0];

	// left[k*4+row], right[col*4+k]
	assign raddr_l  = {k_q, pos_q[K_W-1:0]};
	assign raddr_r  = {pos_q[POS_W-1:K_W], k_q};

	assign op.vld   = issue_q;
	assign op.k     = k_q;
	assign op.pos   = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			pos_q      <= '0;
			k_q        <= '0;
			busy_q     <= 1'b0;
			issue_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						load_cnt_q <= load_cnt_q + 1'b1;
						if (load_cnt_q == {CNT_W{1'b1}}) begin
							state_q <= ST_RUN;
							pos_q   <= '0;
						end
					end
				end
				ST_RUN: begin
					if (start) begin
						busy_q  <= 1'b1;
						issue_q <= 1'b1;
						k_q     <= '0;
					end else if (issue_q) begin
						k_q <= k_q + 1'b1;
						if (k_q == K_LAST) begin
							issue_q <= 1'b0;
						end
					end
					if (res_vld) begin
						busy_q <= 1'b0;
						if (pos_q == POS_LAST) begin
							state_q <= ST_LOAD;
							pos_q   <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

### hw/rtl/matrix4x4_multiply.sv
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Loading: one element per cycle, 32 elements for both matrices.
// Compute: one result at a time through the single shared MAC (start,
// issue of the four terms, read, multiply, accumulate, saturate and output
// stages); the next result starts only once the previous one is taken, so
// each result stall holds back the next result.
// Input is not ready during compute; the last result may wait while loading.
// Asynchronous reset returns to loading with an empty element count.
// ----------------------------------------------------------------------------
module matrix4x4_multiply
	import mm4_pkg::*;
#(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] element,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] product,
	output logic [POS_W-1:0]  position,
	output logic              saturated,
	output logic              final_res
);

	logic              left_we, right_we;
	logic [POS_W-1:0]  waddr, raddr_l, raddr_r;
	logic [DATA_W-1:0] rdata_l, rdata_r;
	op_t               op;
	res_t              res;
	logic              out_valid_q;
	logic [DATA_W-1:0] product_q;
	logic [POS_W-1:0]  position_q;
	logic              saturated_q;
	logic              final_res_q;

	mm4_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_busy (out_valid_q),
		.res_vld  (res.vld),
		.left_we  (left_we),
		.right_we (right_we),
		.waddr    (waddr),
		.raddr_l  (raddr_l),
		.raddr_r  (raddr_r),
		.op       (op)
	);

	mm4_store u_left (
		.clk   (clk),
		.we    (left_we),
		.waddr (waddr),
		.wdata (element),
		.raddr (raddr_l),
		.rdata (rdata_l)
	);

	mm4_store u_right (
		.clk   (clk),
		.we    (right_we),
		.waddr (waddr),
		.wdata (element),
		.raddr (raddr_r),
		.rdata (rdata_r)
	);

	mm4_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.a      (rdata_l),
		.b      (rdata_r),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.vld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			product_q   <= res.product;
			position_q  <= res.position;
			saturated_q <= res.saturated;
			final_res_q <= res.final_res;
		end
	end

	assign out_valid = out_valid_q;
	assign product   = product_q;
	assign position  = position_q;
	assign saturated = saturated_q;
	assign final_res = final_res_q;

endmodule

### hw/rtl/mm4_chk.sv
// ----------------------------------------------------------------------------
// mm4_chk
// Port-level checks for the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_chk
	import mm4_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DATA_W-1:0] product,
	input logic [POS_W-1:0]  position,
	input logic              saturated,
	input logic              final_res
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(product)
			&& $stable(position) && $stable(saturated))
		else $error("result request changed while stalled");

	a_final_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_res == (position == POS_LAST)))
		else $error("final flag not on last position");

	a_final_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_res |=> !out_valid)
		else $error("result after final element");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_res |=> !in_ready)
		else $error("input ready during compute");

endmodule

bind matrix4x4_multiply mm4_chk u_mm4_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.product   (product),
	.position  (position),
	.saturated (saturated),
	.final_res (final_res)
);

### bench/tb_matrix4x4_multiply.sv
// ----------------------------------------------------------------------------
// tb_matrix4x4_multiply
// Streams pairs of 4x4 Q16.16 matrices into the multiplier: two hand-built
// pairs that hit saturation, exact boundaries and floor rounding, then random
// pairs. A local model predicts every product element and the monitor checks
// each result request against it, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_matrix4x4_multiply
	import mm4_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC       = DEF_FRAC_BITS;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_SHOWN  = 10;
	localparam int RAND_PAIRS = 3;

	localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;
	localparam logic [DATA_W-1:0] Q_NEG = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] Q_LSB = 32'h0000_0001;

	typedef struct packed {
		logic [DATA_W-1:0] product;
		logic [POS_W-1:0]  position;
		logic              saturated;
		logic              final_res;
	} mm_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [DATA_W-1:0] element   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DATA_W-1:0] product;
	logic [POS_W-1:0]  position;
	logic              saturated;
	logic              final_res;

	logic [DATA_W-1:0] element_queue[$];
	mm_result_t        product_queue[$];

	logic signed [DATA_W-1:0] lhs_mat[16];
	logic signed [DATA_W-1:0] rhs_mat[16];
	logic [CNT_W-1:0]         load_idx = '0;

	int         in_wait   = 0;
	int         in_mode   = 0;
	int         out_wait  = 0;
	int         out_mode  = 0;
	int         out_draw;
	int         failures  = 0;
	mm_result_t got_res;
	mm_result_t want_res;

	matrix4x4_multiply #(
		.FRAC_BITS(FRAC)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.element   (element),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.product   (product),
		.position  (position),
		.saturated (saturated),
		.final_res (final_res)
	);

	always #6 clk = ~clk;

	function automatic int draw_wait(input int mode);
		if (mode == 0)
			return 0;
		if (mode == 1)
			return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [DATA_W-1:0] rand_element(input int style);
		int pick;
		pick = $urandom_range(0, 9);
		if (style == 0 && pick < 6)
			return $urandom;
		case (pick)
			6:       return ($urandom_range(0, 1) == 0) ? Q_MAX : Q_MIN;
			7:       return 32'($urandom_range(0, 4)) - 32'd2;
			8:       return $urandom;
			default: return 32'($urandom_range(0, 1 << 20)) - 32'h0008_0000;
		endcase
	endfunction

	// 16 product elements of the stored pair, in index order
	task automatic expect_product();
		longint signed acc;
		longint signed a;
		longint signed b;
		mm_result_t    r;
		for (int p = 0; p < 16; p++) begin
			acc = 0;
			for (int k = 0; k < 4; k++) begin
				a = lhs_mat[k * 4 + (p % 4)];
				b = rhs_mat[(p / 4) * 4 + k];
				acc += (a * b) >>> FRAC;
			end
			r.saturated = 1'b1;
			if (acc > 64'sd2147483647)
				r.product = Q_MAX;
			else if (acc < -64'sd2147483648)
				r.product = Q_MIN;
			else begin
				r.product   = acc[DATA_W-1:0];
				r.saturated = 1'b0;
			end
			r.position  = POS_W'(p);
			r.final_res = (POS_W'(p) == POS_LAST);
			product_queue.push_back(r);
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			element  <= '0;
			in_wait  <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_wait != 0) begin
				in_valid <= 1'b0;
				in_wait  <= in_wait - 1;
			end else if (element_queue.size() != 0) begin
				if ($urandom_range(0, 23) == 0)
					in_mode = $urandom_range(0, 2);
				in_valid <= 1'b1;
				element  <= element_queue.pop_front();
				in_wait  <= draw_wait(in_mode);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result-side ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_wait  <= 0;
		end else if (out_valid && out_ready) begin
			if ($urandom_range(0, 23) == 0)
				out_mode = $urandom_range(0, 2);
			out_draw = draw_wait(out_mode);
			out_ready <= (out_draw == 0);
			out_wait  <= out_draw;
		end else if (out_wait != 0) begin
			out_ready <= (out_wait == 1);
			out_wait  <= out_wait - 1;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor: check result requests, then track accepted elements
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_res = '{product, position, saturated, final_res};
			if (product_queue.size() == 0) begin
				failures++;
				if (failures <= MAX_SHOWN)
					$display("unexpected result: product %h pos %0d sat %b final %b",
						got_res.product, got_res.position, got_res.saturated,
						got_res.final_res);
			end else begin
				want_res = product_queue.pop_front();
				if (got_res.product !== want_res.product
						|| got_res.position !== want_res.position
						|| got_res.saturated !== want_res.saturated
						|| got_res.final_res !== want_res.final_res) begin
					failures++;
					if (failures <= MAX_SHOWN)
						$display("mismatch: exp product %h pos %0d sat %b final %b",
							want_res.product, want_res.position,
							want_res.saturated, want_res.final_res,
							", got product %h pos %0d sat %b final %b",
							got_res.product, got_res.position,
							got_res.saturated, got_res.final_res);
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			if (load_idx < 5'd16)
				lhs_mat[load_idx[POS_W-1:0]] = element;
			else
				rhs_mat[load_idx[POS_W-1:0]] = element;
			if (load_idx == 5'd31) begin
				expect_product();
				load_idx = '0;
			end else begin
				load_idx = load_idx + 5'd1;
			end
		end
	end

	// watchdog on cycles with no request moving
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no request for %0d cycles", IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int style;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all-max left: positive and negative clipping, exact max, zero column
		for (int i = 0; i < 16; i++)
			element_queue.push_back(Q_MAX);
		for (int i = 0; i < 16; i++) begin
			case (i / 4)
				0:       element_queue.push_back(Q_MAX);
				1:       element_queue.push_back(Q_MIN);
				2:       element_queue.push_back((i == 8) ? Q_ONE : '0);
				default: element_queue.push_back('0);
			endcase
		end

		// rows 0-1 most negative, rows 2-3 minus one lsb: min*min clipping,
		// exact min and rounding toward minus infinity
		for (int i = 0; i < 16; i++)
			element_queue.push_back(((i % 4) < 2) ? Q_MIN : Q_NEG);
		for (int i = 0; i < 16; i++) begin
			case (i / 4)
				0:       element_queue.push_back(Q_MIN);
				1:       element_queue.push_back((i == 4) ? Q_ONE : '0);
				2:       element_queue.push_back(Q_NEG);
				default: element_queue.push_back(Q_LSB);
			endcase
		end

		for (int g = 0; g < RAND_PAIRS; g++) begin
			style = $urandom_range(0, 1);
			for (int i = 0; i < 32; i++)
				element_queue.push_back(rand_element(style));
		end

		while (element_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (product_queue.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

### matrix4x4_multiply.f
hw/rtl/mm4_pkg.sv
hw/rtl/mm4_store.sv
hw/rtl/mm4_mac.sv
hw/rtl/mm4_seq.sv
hw/rtl/matrix4x4_multiply.sv
hw/rtl/mm4_chk.sv
bench/tb_matrix4x4_multiply.sv
